FILE: src/vector_bitmap_allocator_unit_macros.svh
// Assertion helpers for the allocator sequencer RTL
`ifndef VECTOR_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define VECTOR_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define VBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define VBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/vba_pkg.sv
package vba_pkg;

   // Fixed field widths
   localparam int VEC_W  = 8;
   localparam int WORD_W = 64;
   localparam int SLOT_W = 9;

   typedef enum logic [1:0] {
      OP_ASSIGN  = 2'd0,
      OP_FREE    = 2'd1,
      OP_RESERVE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOSPACE = 3'd1,
      ST_RANGE   = 3'd2,
      ST_DOUBLE  = 3'd3,
      ST_INUSE   = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_FIRST_VECTOR = 1'b0,
      CSR_LAST_VECTOR  = 1'b1
   } csr_index_type;

   typedef struct packed {
      status_type       status;
      logic [VEC_W-1:0] vector;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } done_type;

endpackage

FILE: src/vba_map_mem.sv
module vba_map_mem #(
   parameter int WORDS  = 4,
   parameter int ADDR_W = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [vba_pkg::WORD_W-1:0] wr_data,
   output logic [vba_pkg::WORD_W-1:0] rd_data
);
   import vba_pkg::*;

   logic [WORD_W-1:0] mem [WORDS];
   logic [WORDS-1:0]  row_valid_ff;
   logic [WORDS-1:0]  row_valid_in;
   logic [WORD_W-1:0] rd_raw_ff;
   logic              rd_valid_ff;
   logic              rd_valid_in;

   // Mark a row as written; an unwritten row reads as all clear
   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   assign rd_valid_in = rd_en ? row_valid_ff[rd_addr] : rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   // Storage array, one write and one read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

FILE: src/vba_seq.sv
`include "vector_bitmap_allocator_unit_macros.svh"

module vba_seq #(
   parameter int MAX_SLOTS = 256,
   parameter int ADDR_W    = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_op,
   input  logic [vba_pkg::VEC_W-1:0]  req_vector,
   input  logic [vba_pkg::VEC_W-1:0]  first_vector,
   input  logic [vba_pkg::VEC_W-1:0]  last_vector,
   input  logic                       res_ready,
   output vba_pkg::done_type          res,
   output logic                       mem_rd_en,
   output logic [ADDR_W-1:0]          mem_rd_addr,
   output logic                       mem_wr_en,
   output logic [ADDR_W-1:0]          mem_wr_addr,
   output logic [vba_pkg::WORD_W-1:0] mem_wr_data,
   input  logic [vba_pkg::WORD_W-1:0] mem_rd_data
);
   import vba_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      CHECK,
      DONE
   } state_type;

   localparam logic [SLOT_W-1:0] SLOT_CAP = SLOT_W'(MAX_SLOTS);

   state_type         state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [VEC_W-1:0]  pos_ff, pos_in;
   logic [1:0]        word_ff, word_in;
   result_type        res_ff, res_in;

   logic              accept;
   logic [SLOT_W-1:0] span;
   logic [SLOT_W-1:0] slot_cnt;
   logic [VEC_W-1:0]  pos_req;
   logic              in_range;
   logic [WORD_W-1:0] word_mask;
   logic [WORD_W-1:0] free_bits;
   logic [7:0]        byte_any;
   logic [2:0]        byte_sel;
   logic [7:0]        sel_byte;
   logic [2:0]        bit_sel;
   logic              found;
   logic [5:0]        hit_idx;
   logic [WORD_W-1:0] bit_onehot;
   logic              cur_bit;
   logic [2:0]        next_word;
   logic              more_words;
   logic [1:0]        rd_word;

   assign req_ready = (state_ff == IDLE);
   assign accept    = req_valid && req_ready;

   // Window size, capped at the map size
   always_comb begin
      span = {1'b0, last_vector} - {1'b0, first_vector} + SLOT_W'(1);
      if (first_vector > last_vector) begin
         slot_cnt = '0;
      end else if (span > SLOT_CAP) begin
         slot_cnt = SLOT_CAP;
      end else begin
         slot_cnt = span;
      end
   end

   // Position of the requested vector inside the window
   assign pos_req  = req_vector - first_vector;
   assign in_range = (req_vector >= first_vector) && (req_vector <= last_vector)
                     && ({1'b0, pos_req} < SLOT_CAP);

   // Mask off positions of the current word beyond the window
   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         word_mask[b] = {1'b0, word_ff, 6'(b)} < slot_cnt;
      end
   end

   assign free_bits = ~mem_rd_data & word_mask;

   // Lowest clear position: pick the byte first, then the bit inside it
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         byte_any[k] = |free_bits[k*8 +: 8];
      end
      byte_sel = '0;
      for (int k = 7; k >= 0; k--) begin
         if (byte_any[k]) begin
            byte_sel = 3'(k);
         end
      end
      sel_byte = free_bits[byte_sel*8 +: 8];
      bit_sel  = '0;
      for (int k = 7; k >= 0; k--) begin
         if (sel_byte[k]) begin
            bit_sel = 3'(k);
         end
      end
   end

   assign found      = |byte_any;
   assign hit_idx    = (op_ff == OP_ASSIGN) ? {byte_sel, bit_sel} : pos_ff[5:0];
   assign bit_onehot = WORD_W'(1) << hit_idx;
   assign cur_bit    = mem_rd_data[pos_ff[5:0]];
   assign next_word  = {1'b0, word_ff} + 3'd1;
   assign more_words = {next_word, 6'd0} < slot_cnt;

   // Sequence: read the word, then test, modify and write it back
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      pos_in      = pos_ff;
      word_in     = word_ff;
      res_in      = res_ff;
      mem_rd_en   = 1'b0;
      rd_word     = 2'd0;
      mem_wr_en   = 1'b0;
      mem_wr_data = mem_rd_data | bit_onehot;
      case (state_ff)
         IDLE: begin
            if (accept) begin
               op_in   = req_op;
               pos_in  = pos_req;
               word_in = 2'd0;
               if (req_op == OP_ASSIGN) begin
                  mem_rd_en = 1'b1;
                  state_in  = CHECK;
               end else if ((req_op == OP_FREE) || (req_op == OP_RESERVE)) begin
                  if (in_range) begin
                     word_in   = pos_req[7:6];
                     rd_word   = pos_req[7:6];
                     mem_rd_en = 1'b1;
                     state_in  = CHECK;
                  end else begin
                     res_in.status = ST_RANGE;
                     res_in.vector = '0;
                     state_in      = DONE;
                  end
               end else begin
                  res_in.status = ST_OK;
                  res_in.vector = '0;
                  state_in      = DONE;
               end
            end
         end
         CHECK: begin
            case (op_ff)
               OP_ASSIGN: begin
                  if (found) begin
                     mem_wr_en     = 1'b1;
                     res_in.status = ST_OK;
                     res_in.vector = first_vector + {word_ff, byte_sel, bit_sel};
                     state_in      = DONE;
                  end else if (more_words) begin
                     word_in   = next_word[1:0];
                     rd_word   = next_word[1:0];
                     mem_rd_en = 1'b1;
                  end else begin
                     res_in.status = ST_NOSPACE;
                     res_in.vector = '0;
                     state_in      = DONE;
                  end
               end
               OP_FREE: begin
                  res_in.vector = '0;
                  if (cur_bit) begin
                     mem_wr_en     = 1'b1;
                     mem_wr_data   = mem_rd_data & ~bit_onehot;
                     res_in.status = ST_OK;
                  end else begin
                     res_in.status = ST_DOUBLE;
                  end
                  state_in = DONE;
               end
               OP_RESERVE: begin
                  res_in.vector = '0;
                  if (cur_bit) begin
                     res_in.status = ST_INUSE;
                  end else begin
                     mem_wr_en     = 1'b1;
                     res_in.status = ST_OK;
                  end
                  state_in = DONE;
               end
               default: begin
                  res_in.status = ST_OK;
                  res_in.vector = '0;
                  state_in      = DONE;
               end
            endcase
         end
         DONE: begin
            if (res_ready) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   assign mem_rd_addr = rd_word[ADDR_W-1:0];
   assign mem_wr_addr = word_ff[ADDR_W-1:0];

   // Hold state and the result under construction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff   <= op_in;
      pos_ff  <= pos_in;
      word_ff <= word_in;
      res_ff  <= res_in;
   end

   assign res.valid  = (state_ff == DONE);
   assign res.result = res_ff;

   `VBA_ASSERT_NEXT(a_write_gives_ok, clock, reset, mem_wr_en, (state_ff == DONE) && (res_ff.status == ST_OK), "map written without an ok result")
   `VBA_ASSERT_SAME(a_vector_zero_on_error, clock, reset, res.valid && (res.result.status != ST_OK), res.result.vector == '0, "vector granted with error status")
   `VBA_ASSERT_NEXT(a_read_is_checked, clock, reset, mem_rd_en, state_ff == CHECK, "map read data left unused")
   `VBA_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, accept, !req_ready, "second item taken while one is in progress")

endmodule

FILE: src/vector_bitmap_allocator_unit.sv
// Channel | Direction | Handshake               | Content
// req     | in        | req_tvalid / req_tready | tuser op, tdata vector_in
// rsp     | out       | rsp_tvalid / rsp_tready | tuser status, tdata vector_out
// csr     | in        | csr_valid / csr_ready   | csr_index register, csr_data value
//
// Free and reserve read and check the word of the vector; out-of-range vectors and
// unused ops go straight to the result. Assign scans map words (up to 4 at 256 slots);
// the map memory reads one 64-bit word per cycle and writes the word back on a hit.
// Reset is synchronous; it clears the map by row valid bits at once, no clearing pass.
// The result sits in an output register, so a new item is taken while it waits;
// a stalled rsp channel holds the following result in the sequencer.
module vector_bitmap_allocator_unit #(
   parameter int MAX_SLOTS = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [vba_pkg::VEC_W-1:0] req_tdata,   // [7:0] vector_in
   input  logic [1:0]                req_tuser,   // [1:0] op
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [vba_pkg::VEC_W-1:0] rsp_tdata,   // [7:0] vector_out
   output logic [2:0]                rsp_tuser,   // [2:0] status
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [0:0]                csr_index,
   input  logic [vba_pkg::VEC_W-1:0] csr_data
);
   import vba_pkg::*;

   localparam int WORDS  = (MAX_SLOTS + 63) / 64;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [VEC_W-1:0]  first_ff, first_in;
   logic [VEC_W-1:0]  last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_res_ff, rsp_res_in;

   done_type          res;
   logic              res_ready;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic [WORD_W-1:0] mem_rd_data;

   // Window registers
   assign csr_ready = 1'b1;

   always_comb begin
      first_in = first_ff;
      last_in  = last_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FIRST_VECTOR) begin
            first_in = csr_data;
         end else begin
            last_in = csr_data;
         end
      end
   end

   // Output register: load on a free slot or when the held result transfers
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res.valid ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   assign rsp_res_in   = (res.valid && res_ready) ? res.result : rsp_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= VEC_W'(48);
         last_ff      <= VEC_W'(231);
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_res_ff.vector;
   assign rsp_tuser  = rsp_res_ff.status;

   vba_seq #(
      .MAX_SLOTS (MAX_SLOTS),
      .ADDR_W    (ADDR_W)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (req_tuser),
      .req_vector   (req_tdata),
      .first_vector (first_ff),
      .last_vector  (last_ff),
      .res_ready    (res_ready),
      .res          (res),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_data  (mem_rd_data)
   );

   vba_map_mem #(
      .WORDS  (WORDS),
      .ADDR_W (ADDR_W)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule
